// ===== hw/rtl/slr_pkg.sv =====
// Shared types and constants of the stroke line rasterizer.
// Used by every module of the block; depends on nothing.
package slr_pkg;

  localparam int unsigned CoordW   = 6;
  localparam int unsigned MapDimW  = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned ErrW     = 8;
  localparam int unsigned GridDimDefault = 64;

  localparam logic [MapDimW-1:0] MapWidthReset  = 7'd64;
  localparam logic [MapDimW-1:0] MapHeightReset = 7'd64;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_MOVE    = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAP_WIDTH     = 2'd0,
    CFG_MAP_HEIGHT    = 2'd1,
    CFG_ITEM_SELECTED = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWAP,
    ST_ORDER,
    ST_DRAW
  } state_e;

  typedef struct packed {
    logic [MapDimW-1:0] map_width;
    logic [MapDimW-1:0] map_height;
    logic               item_selected;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic swap;
    logic order;
    logic step;
  } step_ctrl_t;

  typedef struct packed {
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic              done;
  } step_stat_t;

endpackage

// ===== hw/rtl/slr_cfg_regs.sv =====
// Configuration registers of the stroke line rasterizer: map size and item flag.
// Depends on slr_pkg for the register indexes and reset values.
module slr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [slr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [slr_pkg::CfgDataW-1:0]  cfg_data_i,
  output slr_pkg::cfg_t                 cfg_o
);

  slr_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        slr_pkg::CFG_MAP_WIDTH:     cfg_d.map_width     = cfg_data_i;
        slr_pkg::CFG_MAP_HEIGHT:    cfg_d.map_height    = cfg_data_i;
        slr_pkg::CFG_ITEM_SELECTED: cfg_d.item_selected = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width     <= slr_pkg::MapWidthReset;
      cfg_q.map_height    <= slr_pkg::MapHeightReset;
      cfg_q.item_selected <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/slr_stepper.sv =====
// Iterative Bresenham unit: axis swap, endpoint ordering, then one point per step.
// Controlled by the sequencer in the top level; depends on slr_pkg.
module slr_stepper (
  input  logic                        clk_i,
  input  slr_pkg::step_ctrl_t         ctrl_i,
  input  logic [slr_pkg::CoordW-1:0]  x0_i,
  input  logic [slr_pkg::CoordW-1:0]  y0_i,
  input  logic [slr_pkg::CoordW-1:0]  x1_i,
  input  logic [slr_pkg::CoordW-1:0]  y1_i,
  output slr_pkg::step_stat_t         stat_o
);

  localparam int unsigned CW = slr_pkg::CoordW;
  localparam int unsigned EW = slr_pkg::ErrW;

  logic [CW-1:0] maj_q, min_q, end_maj_q, end_min_q;
  logic [CW-1:0] dx_q, dy_q;
  logic          steep_q, ystep_neg_q;
  logic [EW-1:0] err_q;

  logic [CW-1:0] adx, ady;
  logic          steep;
  logic          gt;
  logic [CW-1:0] s_maj, s_min, e_maj, e_min;
  logic          neg;
  logic [CW-1:0] dx, dy;
  logic [EW-1:0] err_sub;

  always_comb begin
    adx   = (maj_q >= end_maj_q) ? (maj_q - end_maj_q) : (end_maj_q - maj_q);
    ady   = (min_q >= end_min_q) ? (min_q - end_min_q) : (end_min_q - min_q);
    steep = ady > adx;

    gt    = maj_q > end_maj_q;
    s_maj = gt ? end_maj_q : maj_q;
    s_min = gt ? end_min_q : min_q;
    e_maj = gt ? maj_q : end_maj_q;
    e_min = gt ? min_q : end_min_q;
    neg   = s_min > e_min;
    dx    = e_maj - s_maj;
    dy    = neg ? (s_min - e_min) : (e_min - s_min);

    err_sub = err_q - {{(EW-CW){1'b0}}, dy_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      maj_q     <= x0_i;
      min_q     <= y0_i;
      end_maj_q <= x1_i;
      end_min_q <= y1_i;
    end else if (ctrl_i.swap) begin
      steep_q <= steep;
      if (steep) begin
        maj_q     <= min_q;
        min_q     <= maj_q;
        end_maj_q <= end_min_q;
        end_min_q <= end_maj_q;
      end
    end else if (ctrl_i.order) begin
      maj_q       <= s_maj;
      min_q       <= s_min;
      end_maj_q   <= e_maj;
      end_min_q   <= e_min;
      dx_q        <= dx;
      dy_q        <= dy;
      ystep_neg_q <= neg;
      err_q       <= {{(EW-CW+1){1'b0}}, dx[CW-1:1]};
    end else if (ctrl_i.step) begin
      maj_q <= maj_q + 1'b1;
      if (err_sub[EW-1]) begin
        min_q <= ystep_neg_q ? (min_q - 1'b1) : (min_q + 1'b1);
        err_q <= err_sub + {{(EW-CW){1'b0}}, dx_q};
      end else begin
        err_q <= err_sub;
      end
    end
  end

  assign stat_o.point_x = steep_q ? min_q : maj_q;
  assign stat_o.point_y = steep_q ? maj_q : min_q;
  assign stat_o.done    = maj_q == end_maj_q;

endmodule

// ===== hw/rtl/stroke_line_rasterizer.sv =====
// Top level of the stroke line rasterizer: event decode, anchor, sequencer, output register.
// Instantiates slr_cfg_regs and slr_stepper; depends on slr_pkg.
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       in_valid_i / in_stall_o    opcode, left_button, tile_x, tile_y
//   out      source     out_valid_o / out_stall_i  point_x, point_y, in_bounds, last
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An event that draws goes through line setup in the shared stepper (load, swap, order),
// then yields its points; other events are taken without setup. The stepper's single add
// and compare path sets the rate of one point per cycle while the output is not stalled.
// The input is stalled while a line is being drawn; an output stall holds the stepper.
// Reset clears the anchor, the sequencer and the output valid and loads the map size.
module stroke_line_rasterizer #(
  parameter int unsigned GRID_DIM = slr_pkg::GridDimDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_opcode_i,
  input  logic                          in_left_button_i,
  input  logic [slr_pkg::CoordW-1:0]    in_tile_x_i,
  input  logic [slr_pkg::CoordW-1:0]    in_tile_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [slr_pkg::CoordW-1:0]    out_point_x_o,
  output logic [slr_pkg::CoordW-1:0]    out_point_y_o,
  output logic                          out_in_bounds_o,
  output logic                          out_last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [slr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [slr_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned CW = slr_pkg::CoordW;
  localparam logic [CW-1:0] MaxCoord = CW'(GRID_DIM - 1);

  slr_pkg::cfg_t       cfg;
  slr_pkg::step_ctrl_t ctrl;
  slr_pkg::step_stat_t stat;
  slr_pkg::state_e     state_q, state_d;

  logic [CW-1:0] anchor_x_q, anchor_y_q, anchor_x_d, anchor_y_d;
  logic          anchor_valid_q, anchor_valid_d;

  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] out_x_q, out_y_q;
  logic          out_in_bounds_q, out_last_q;

  logic          in_fire, start, advance;
  logic [CW-1:0] tx, ty, x0, y0;
  logic          at_anchor;

  slr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  slr_stepper u_stepper (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .x0_i   (x0),
    .y0_i   (y0),
    .x1_i   (tx),
    .y1_i   (ty),
    .stat_o (stat)
  );

  assign in_fire = in_valid_i && !in_stall_o;
  assign advance = !out_valid_q || !out_stall_i;

  // Event decode and anchor update.
  always_comb begin
    tx = (in_tile_x_i > MaxCoord) ? MaxCoord : in_tile_x_i;
    ty = (in_tile_y_i > MaxCoord) ? MaxCoord : in_tile_y_i;
    at_anchor      = anchor_valid_q && (anchor_x_q == tx) && (anchor_y_q == ty);
    start          = 1'b0;
    x0             = tx;
    y0             = ty;
    anchor_x_d     = anchor_x_q;
    anchor_y_d     = anchor_y_q;
    anchor_valid_d = anchor_valid_q;
    if (in_fire) begin
      case (in_opcode_i)
        slr_pkg::OP_PRESS: begin
          if (in_left_button_i && cfg.item_selected) begin
            start          = 1'b1;
            anchor_x_d     = tx;
            anchor_y_d     = ty;
            anchor_valid_d = 1'b1;
          end
        end
        slr_pkg::OP_MOVE: begin
          if (in_left_button_i && !at_anchor) begin
            start          = cfg.item_selected;
            if (anchor_valid_q) begin
              x0 = anchor_x_q;
              y0 = anchor_y_q;
            end
            anchor_x_d     = tx;
            anchor_y_d     = ty;
            anchor_valid_d = 1'b1;
          end
        end
        slr_pkg::OP_RELEASE: anchor_valid_d = 1'b0;
        default: ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      slr_pkg::ST_IDLE:  if (start) state_d = slr_pkg::ST_SWAP;
      slr_pkg::ST_SWAP:  state_d = slr_pkg::ST_ORDER;
      slr_pkg::ST_ORDER: state_d = slr_pkg::ST_DRAW;
      slr_pkg::ST_DRAW:  if (advance && stat.done) state_d = slr_pkg::ST_IDLE;
      default:           state_d = slr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctrl       = '0;
    in_stall_o = 1'b1;
    case (state_q)
      slr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        ctrl.load  = start;
      end
      slr_pkg::ST_SWAP:  ctrl.swap  = 1'b1;
      slr_pkg::ST_ORDER: ctrl.order = 1'b1;
      slr_pkg::ST_DRAW:  ctrl.step  = advance;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= slr_pkg::ST_IDLE;
      anchor_x_q     <= '0;
      anchor_y_q     <= '0;
      anchor_valid_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      anchor_x_q     <= anchor_x_d;
      anchor_y_q     <= anchor_y_d;
      anchor_valid_q <= anchor_valid_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.step) begin
      out_x_q         <= stat.point_x;
      out_y_q         <= stat.point_y;
      out_in_bounds_q <= ({1'b0, stat.point_x} < cfg.map_width) &&
                         ({1'b0, stat.point_y} < cfg.map_height);
      out_last_q      <= stat.done;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_point_x_o   = out_x_q;
  assign out_point_y_o   = out_y_q;
  assign out_in_bounds_o = out_in_bounds_q;
  assign out_last_o      = out_last_q;

endmodule

// ===== tb/stroke_line_rasterizer_tb.sv =====
// Self-checking testbench for the stroke line rasterizer: pointer events in, line points out.
// Holds its own line tracer and a scoreboard class; depends on slr_pkg and the block only.
`timescale 1ns / 100ps

module stroke_line_rasterizer_tb;

  localparam int ClkHalf = 5;
  localparam int GridDim = 64;
  localparam int DrainCycles = GridDim + 16;
  localparam int LongHold = 400;
  localparam int CycleLimit = 1000000;
  localparam int unsigned CW = slr_pkg::CoordW;
  localparam int unsigned MW = slr_pkg::MapDimW;
  localparam int unsigned DW = slr_pkg::CfgDataW;
  localparam int unsigned IW = slr_pkg::CfgIdxW;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          in_bounds;
    logic          last;
  } point_t;

  class point_scoreboard;
    point_t        point_q[$];
    logic [MW-1:0] map_w;
    logic [MW-1:0] map_h;
    logic          item_sel;
    logic [CW-1:0] anc_x;
    logic [CW-1:0] anc_y;
    logic          anc_valid;
    int unsigned   fail_count;

    function new();
      map_w = slr_pkg::MapWidthReset;
      map_h = slr_pkg::MapHeightReset;
      item_sel = 1'b0;
      anc_x = '0;
      anc_y = '0;
      anc_valid = 1'b0;
      fail_count = 0;
    endfunction

    function void write_reg(slr_pkg::cfg_idx_e idx, logic [DW-1:0] data);
      case (idx)
        slr_pkg::CFG_MAP_WIDTH: map_w = data;
        slr_pkg::CFG_MAP_HEIGHT: map_h = data;
        slr_pkg::CFG_ITEM_SELECTED: item_sel = data[0];
        default: ;
      endcase
    endfunction

    function void push_point(int x, int y);
      point_t p;
      p.x = x[CW-1:0];
      p.y = y[CW-1:0];
      p.in_bounds = (x < int'(map_w)) && (y < int'(map_h));
      p.last = 1'b0;
      point_q.push_back(p);
    endfunction

    function void trace_line(int ax, int ay, int bx, int by);
      int x0, y0, x1, y1, t, dx, dy, err, ystep, y, x, n;
      bit steep;
      x0 = ax;
      y0 = ay;
      x1 = bx;
      y1 = by;
      n = 0;
      steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
      if (steep) begin
        t = x0; x0 = y0; y0 = t;
        t = x1; x1 = y1; y1 = t;
      end
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      dx = x1 - x0;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      err = dx / 2;
      ystep = (y0 < y1) ? 1 : -1;
      y = y0;
      for (x = x0; x <= x1 && n < GridDim; x++) begin
        if (steep) begin
          push_point(y, x);
        end else begin
          push_point(x, y);
        end
        n++;
        err -= dy;
        if (err < 0) begin
          y += ystep;
          err += dx;
        end
      end
    endfunction

    function void note_event(logic [1:0] op, logic left, logic [CW-1:0] tx,
                             logic [CW-1:0] ty);
      int first;
      first = point_q.size();
      case (op)
        slr_pkg::OP_PRESS: begin
          if (left && item_sel) begin
            push_point(int'(tx), int'(ty));
            anc_x = tx;
            anc_y = ty;
            anc_valid = 1'b1;
          end
        end
        slr_pkg::OP_MOVE: begin
          if (left && !(anc_valid && anc_x == tx && anc_y == ty)) begin
            if (item_sel) begin
              if (!anc_valid) begin
                push_point(int'(tx), int'(ty));
              end else begin
                trace_line(int'(anc_x), int'(anc_y), int'(tx), int'(ty));
              end
            end
            anc_x = tx;
            anc_y = ty;
            anc_valid = 1'b1;
          end
        end
        slr_pkg::OP_RELEASE: anc_valid = 1'b0;
        default: ;
      endcase
      if (point_q.size() > first) begin
        point_q[point_q.size()-1].last = 1'b1;
      end
    endfunction

    function void check_point(logic [CW-1:0] x, logic [CW-1:0] y, logic in_bounds,
                              logic last);
      point_t exp_pt;
      if (point_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected point x=%0d y=%0d in_bounds=%0b last=%0b",
                 $time, x, y, in_bounds, last);
        return;
      end
      exp_pt = point_q.pop_front();
      if (x !== exp_pt.x || y !== exp_pt.y || in_bounds !== exp_pt.in_bounds ||
          last !== exp_pt.last) begin
        fail_count++;
        $display("%0t: point mismatch: expected x=%0d y=%0d in_bounds=%0b last=%0b,",
                 $time, exp_pt.x, exp_pt.y, exp_pt.in_bounds, exp_pt.last);
        $display("    got x=%0d y=%0d in_bounds=%0b last=%0b", x, y, in_bounds, last);
      end
    endfunction

    function int pending();
      return point_q.size();
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  logic [1:0]     in_opcode_i = '0;
  logic           in_left_button_i = 1'b0;
  logic [CW-1:0]  in_tile_x_i = '0;
  logic [CW-1:0]  in_tile_y_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  logic [CW-1:0]  out_point_x_o;
  logic [CW-1:0]  out_point_y_o;
  logic           out_in_bounds_o;
  logic           out_last_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [IW-1:0]  cfg_index_i = '0;
  logic [DW-1:0]  cfg_data_i = '0;

  point_scoreboard sb;
  bit              no_idle;
  bit              hold_req;
  int              cycle_count = 0;

  stroke_line_rasterizer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_opcode_i      (in_opcode_i),
    .in_left_button_i (in_left_button_i),
    .in_tile_x_i      (in_tile_x_i),
    .in_tile_y_i      (in_tile_y_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_point_x_o    (out_point_x_o),
    .out_point_y_o    (out_point_y_o),
    .out_in_bounds_o  (out_in_bounds_o),
    .out_last_o       (out_last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #ClkHalf clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("stroke_line_rasterizer_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_point(out_point_x_o, out_point_y_o, out_in_bounds_o, out_last_o);
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 6));
  endfunction

  initial begin : rx_side
    int gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        gap_left = draw_gap();
        out_stall_i <= (gap_left > 0);
      end else if (gap_left > 0) begin
        gap_left--;
        out_stall_i <= (gap_left > 0);
      end
    end
  end

  task automatic send_event(logic [1:0] op, logic left, logic [CW-1:0] x,
                            logic [CW-1:0] y);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_opcode_i <= op;
    in_left_button_i <= left;
    in_tile_x_i <= x;
    in_tile_y_i <= y;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(op, left, x, y);
  endtask

  task automatic write_reg(slr_pkg::cfg_idx_e idx, logic [DW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic write_cfg(logic [MW-1:0] w, logic [MW-1:0] h, logic sel);
    write_reg(slr_pkg::CFG_MAP_WIDTH, w);
    write_reg(slr_pkg::CFG_MAP_HEIGHT, h);
    write_reg(slr_pkg::CFG_ITEM_SELECTED, {{(DW-1){1'b0}}, sel});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [CW-1:0] pick_tile();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CW'(GridDim - 1);
      default: return CW'($urandom_range(0, GridDim - 1));
    endcase
  endfunction

  function automatic logic [CW-1:0] near_tile(logic [CW-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > GridDim - 1) v = GridDim - 1;
    return CW'(v);
  endfunction

  task automatic random_traffic(int n);
    int sent, moves;
    logic [CW-1:0] cx, cy;
    logic [1:0] op;
    logic left;
    sent = 0;
    while (sent < n) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        cx = pick_tile();
        cy = pick_tile();
        send_event(slr_pkg::OP_PRESS, 1'b1, cx, cy);
        moves = int'($urandom_range(1, 6));
        repeat (moves) begin
          if ($urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 9) < 6) begin
              cx = near_tile(cx);
              cy = near_tile(cy);
            end else begin
              cx = pick_tile();
              cy = pick_tile();
            end
          end
          send_event(slr_pkg::OP_MOVE, 1'b1, cx, cy);
        end
        sent += moves + 1;
        if ($urandom_range(0, 3) != 0) begin
          send_event(slr_pkg::OP_RELEASE, 1'($urandom_range(0, 1)), cx, cy);
          sent++;
        end
      end else begin
        op = 2'($urandom_range(0, 3));
        left = 1'($urandom_range(0, 1));
        send_event(op, left, pick_tile(), pick_tile());
        sent++;
      end
    end
  endtask

  task automatic run_phase(logic [MW-1:0] w, logic [MW-1:0] h, logic sel, int n);
    wait_idle();
    write_cfg(w, h, sel);
    random_traffic(n);
  endtask

  initial begin
    sb = new();
    no_idle = 1'b0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With no brush chosen nothing is drawn, but moves still set the anchor.
    send_event(slr_pkg::OP_PRESS, 1'b1, 6'd5, 6'd5);
    send_event(slr_pkg::OP_MOVE, 1'b1, 6'd10, 6'd10);
    send_event(slr_pkg::OP_RELEASE, 1'b0, 6'd0, 6'd0);
    send_event(slr_pkg::OP_MOVE, 1'b1, 6'd3, 6'd3);
    wait_idle();
    write_cfg(7'd64, 7'd64, 1'b1);

    send_event(slr_pkg::OP_MOVE, 1'b1, 6'd3, 6'd3);
    send_event(slr_pkg::OP_MOVE, 1'b1, 6'd0, 6'd0);
    send_event(slr_pkg::OP_MOVE, 1'b1, 6'd63, 6'd63);
    send_event(slr_pkg::OP_MOVE, 1'b1, 6'd0, 6'd63);
    send_event(slr_pkg::OP_MOVE, 1'b1, 6'd0, 6'd0);
    send_event(slr_pkg::OP_MOVE, 1'b1, 6'd63, 6'd0);
    send_event(slr_pkg::OP_MOVE, 1'b1, 6'd20, 6'd5);
    send_event(slr_pkg::OP_MOVE, 1'b1, 6'd23, 6'd40);
    send_event(slr_pkg::OP_MOVE, 1'b0, 6'd50, 6'd50);
    send_event(slr_pkg::OP_PRESS, 1'b0, 6'd50, 6'd50);
    send_event(OpUnused, 1'b1, 6'd50, 6'd50);
    send_event(slr_pkg::OP_RELEASE, 1'b0, 6'd0, 6'd0);
    send_event(slr_pkg::OP_MOVE, 1'b1, 6'd40, 6'd40);
    send_event(slr_pkg::OP_RELEASE, 1'b1, 6'd63, 6'd63);
    send_event(slr_pkg::OP_PRESS, 1'b1, 6'd63, 6'd0);
    send_event(slr_pkg::OP_MOVE, 1'b1, 6'd62, 6'd1);
    send_event(slr_pkg::OP_PRESS, 1'b1, 6'd0, 6'd63);

    run_phase(7'd0, 7'd0, 1'b1, 30);
    run_phase(7'd1, 7'd1, 1'b1, 30);
    run_phase(7'd127, 7'd127, 1'b1, 30);
    hold_req = 1'b1;
    run_phase(7'd64, 7'd64, 1'b1, 90);
    run_phase(MW'($urandom_range(1, 64)), MW'($urandom_range(1, 64)), 1'b1, 90);
    run_phase(MW'($urandom_range(0, 127)), MW'($urandom_range(0, 127)), 1'b0, 30);
    run_phase(MW'($urandom_range(0, 127)), MW'($urandom_range(0, 127)), 1'b1, 90);
    wait_idle();

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("stroke_line_rasterizer_tb OK");
    end else begin
      $display("stroke_line_rasterizer_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/slr_pkg.sv
hw/rtl/slr_cfg_regs.sv
hw/rtl/slr_stepper.sv
hw/rtl/stroke_line_rasterizer.sv
tb/stroke_line_rasterizer_tb.sv
